>>> hdl/eifw_pkg.sv
package eifw_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned ENERGY_W = 64;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned DEC_W    = 8;
  localparam int unsigned WRAP_W   = 32;
  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;

  localparam int unsigned SQUARE_SHIFT    = 2;
  localparam int unsigned FAST_IN_SHIFT   = 8;
  localparam int unsigned FAST_MUL_SHIFT  = 0;
  localparam int unsigned DECIMATION_LOG2 = 3;
  localparam int unsigned MUL_BASE_SHIFT  = 5;

  localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(33550);
  localparam logic [DEC_W-1:0]  DEC_MASK   = DEC_W'((1 << DECIMATION_LOG2) - 1);

  // two's complement magnitude; the most negative word maps to 2^31 as unsigned
  function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] v);
    return v[SAMPLE_W-1] ? (~v + SAMPLE_W'(1)) : v;
  endfunction

endpackage

>>> hdl/energy_integrator_fast_weighting.sv
// channel | handshake           | payload
// --------+---------------------+------------------------------
// in      | in_valid, in_ready   | weighted_sample
// out     | out_valid, out_ready | fast_level, wrap_count
// cfg     | cfg_valid, cfg_ready | fast_coefficient
//
// One item per cycle sustained while no held result stalls the pipe. Pipeline: input register, squarer register,
// integrator / decimator, filter with output register; a snapshot item passes
// each of these registers in order. Only snapshot items produce a result.
// Reset (rst, synchronous) clears the integrator, counters and filter and loads
// the coefficient reset value; in_ready and cfg_ready are low during reset.
// A held result stops the next snapshot item in the integrator stage; items
// behind it then back up, and in_ready drops once the squarer stages are full.
module energy_integrator_fast_weighting
  import eifw_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] weighted_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] fast_level,
  output logic [WRAP_W-1:0]          wrap_count,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [COEF_W-1:0]          fast_coefficient
);

  logic [COEF_W-1:0]   coef;
  logic                sq_valid;
  logic                sq_ready;
  logic [ENERGY_W-1:0] sq;
  logic                snap_valid;
  logic                snap_ready;
  logic [ENERGY_W-1:0] energy_snap;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= COEF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      coef <= fast_coefficient;
    end
  end

  eifw_square u_square (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .weighted_sample (weighted_sample),
    .sq_valid        (sq_valid),
    .sq_ready        (sq_ready),
    .sq              (sq)
  );

  eifw_integrate u_integrate (
    .clk         (clk),
    .rst         (rst),
    .sq_valid    (sq_valid),
    .sq_ready    (sq_ready),
    .sq          (sq),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .energy_snap (energy_snap)
  );

  eifw_filter u_filter (
    .clk         (clk),
    .rst         (rst),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .energy_snap (energy_snap),
    .coef        (coef),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .fast_level  (fast_level),
    .wrap_count  (wrap_count)
  );

endmodule

>>> hdl/eifw_square.sv
module eifw_square
  import eifw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] weighted_sample,
  output logic                sq_valid,
  input  logic                sq_ready,
  output logic [ENERGY_W-1:0] sq
);

  logic                s0_valid;
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] shifted;
  logic [SAMPLE_W-1:0] mag;
  logic [ENERGY_W-1:0] sq_next;
  logic                sq_free;
  logic                load1;

  assign sq_free  = !sq_valid || sq_ready;
  assign load1    = s0_valid && sq_free;
  assign in_ready = !rst && (!s0_valid || load1);

  // bits shifted past the top are dropped
  assign shifted = sample << SQUARE_SHIFT;
  assign mag     = magnitude(shifted);
  assign sq_next = ENERGY_W'(mag) * ENERGY_W'(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample <= weighted_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (sq_free) begin
      sq_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      sq <= sq_next;
    end
  end

endmodule

>>> hdl/eifw_integrate.sv
module eifw_integrate
  import eifw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                sq_valid,
  output logic                sq_ready,
  input  logic [ENERGY_W-1:0] sq,
  output logic                snap_valid,
  input  logic                snap_ready,
  output logic [ENERGY_W-1:0] energy_snap
);

  logic [ENERGY_W-1:0] energy_sum;
  logic [ENERGY_W-1:0] energy_sum_next;
  logic [DEC_W-1:0]    decimation_count;
  logic                load2;
  logic                is_snap;

  assign sq_ready        = !snap_valid || snap_ready;
  assign load2           = sq_valid && sq_ready;
  assign energy_sum_next = energy_sum + sq;
  assign is_snap         = (decimation_count & DEC_MASK) == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_sum       <= '0;
      decimation_count <= '0;
    end else if (load2) begin
      energy_sum       <= energy_sum_next;
      decimation_count <= decimation_count + DEC_W'(1);
    end
  end

  // only snapshot items move on; the rest just accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (load2 && is_snap) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load2 && is_snap) begin
      energy_snap <= energy_sum_next;
    end
  end

endmodule

>>> hdl/eifw_filter.sv
module eifw_filter
  import eifw_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       snap_valid,
  output logic                       snap_ready,
  input  logic [ENERGY_W-1:0]        energy_snap,
  input  logic [COEF_W-1:0]          coef,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] fast_level,
  output logic [WRAP_W-1:0]          wrap_count
);

  logic [ENERGY_W-1:0] previous_snapshot;
  logic [ENERGY_W-1:0] filter_delay;
  logic [ENERGY_W-1:0] filter_output;
  logic [WRAP_W-1:0]   high_wraps;

  logic [ENERGY_W-1:0] x;
  logic [SAMPLE_W-1:0] upper;
  logic [SAMPLE_W-1:0] upper_mag;
  logic [PROD_W-1:0]   prod;
  logic [ENERGY_W-1:0] prod_shifted;
  logic [ENERGY_W-1:0] m;
  logic [ENERGY_W-1:0] filter_output_next;
  logic [ENERGY_W-1:0] filter_delay_next;
  logic [WRAP_W-1:0]   high_wraps_next;
  logic                take;

  assign snap_ready = !out_valid || out_ready;
  assign take       = snap_valid && snap_ready;

  assign x = (energy_snap - previous_snapshot) >> FAST_IN_SHIFT;

  // sign-magnitude feedback product, exact in 64 bits
  assign upper        = filter_output[ENERGY_W-1:SAMPLE_W];
  assign upper_mag    = magnitude(upper);
  assign prod         = PROD_W'(upper_mag) * PROD_W'(coef);
  assign prod_shifted = ENERGY_W'(prod) << (MUL_BASE_SHIFT + FAST_MUL_SHIFT);
  assign m            = upper[SAMPLE_W-1] ? (~prod_shifted + ENERGY_W'(1)) : prod_shifted;

  assign filter_output_next = x + filter_delay;
  assign filter_delay_next  = x + (filter_output - m);
  assign high_wraps_next    = (previous_snapshot[ENERGY_W-1:SAMPLE_W] >
                               energy_snap[ENERGY_W-1:SAMPLE_W]) ?
                              high_wraps + WRAP_W'(1) : high_wraps;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_snapshot <= '0;
      filter_delay      <= '0;
      filter_output     <= '0;
      high_wraps        <= '0;
    end else if (take) begin
      previous_snapshot <= energy_snap;
      filter_delay      <= filter_delay_next;
      filter_output     <= filter_output_next;
      high_wraps        <= high_wraps_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fast_level <= filter_output_next[ENERGY_W-1:SAMPLE_W];
      wrap_count <= high_wraps_next;
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import eifw_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX = 10;

  localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [24] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h2000_0000, 32'hE000_0000, 32'h1FFF_FFFF,
    32'hE000_0001, 32'h4000_0000, 32'hC000_0000, 32'h5555_5555,
    32'hAAAA_AAAA, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000,
    32'h2000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_FFFF,
    32'h1234_5678, 32'hEDCB_A987, 32'h3FFF_FFFF, 32'h6000_0000
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic [WRAP_W-1:0]   wraps;
  } level_result_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] weighted_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] fast_level;
  logic [WRAP_W-1:0]          wrap_count;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [COEF_W-1:0]          fast_coefficient = '0;

  // predictor state
  logic [COEF_W-1:0]   coef_shadow;
  logic [ENERGY_W-1:0] energy_acc;
  logic [DEC_W-1:0]    sample_index;
  logic [ENERGY_W-1:0] last_snapshot;
  logic [ENERGY_W-1:0] weight_delay;
  logic [ENERGY_W-1:0] weight_out;
  logic [WRAP_W-1:0]   wrap_total;
  level_result_t       level_queue [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int idle_cycles = 0;

  logic                out_fire = 1'b0;
  logic [SAMPLE_W-1:0] out_level_q;
  logic [WRAP_W-1:0]   out_wraps_q;

  energy_integrator_fast_weighting uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .weighted_sample  (weighted_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .fast_level       (fast_level),
    .wrap_count       (wrap_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .fast_coefficient (fast_coefficient)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // sign-magnitude feedback product, exact in 64 bits
  function automatic logic [ENERGY_W-1:0] feedback_term(logic [SAMPLE_W-1:0] a,
                                                        logic [COEF_W-1:0] k);
    logic [ENERGY_W-1:0] mag;
    logic [ENERGY_W-1:0] prod;
    mag = a[SAMPLE_W-1] ? {32'd0, ~a + 32'd1} : {32'd0, a};
    prod = (mag * {48'd0, k}) << (MUL_BASE_SHIFT + FAST_MUL_SHIFT);
    return a[SAMPLE_W-1] ? ~prod + 64'd1 : prod;
  endfunction

  function automatic void integrate_sample(logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] shifted;
    logic [SAMPLE_W-1:0] mag;
    logic [DEC_W-1:0]    idx;
    logic [ENERGY_W-1:0] x;
    logic [ENERGY_W-1:0] m;
    logic [ENERGY_W-1:0] next_out;
    level_result_t       res;
    shifted = s << SQUARE_SHIFT;
    // the most negative word negates to itself, read as 2^31 unsigned
    mag = shifted[SAMPLE_W-1] ? ~shifted + 32'd1 : shifted;
    idx = sample_index;
    energy_acc = energy_acc + {32'd0, mag} * {32'd0, mag};
    sample_index = idx + 8'd1;
    if ((idx & DEC_MASK) != '0) return;
    x = (energy_acc - last_snapshot) >> FAST_IN_SHIFT;
    m = feedback_term(weight_out[63:32], coef_shadow);
    next_out = x + weight_delay;
    weight_delay = x + weight_out - m;
    weight_out = next_out;
    if (last_snapshot[63:32] > energy_acc[63:32]) wrap_total = wrap_total + 32'd1;
    last_snapshot = energy_acc;
    res.level = weight_out[63:32];
    res.wraps = wrap_total;
    level_queue.push_back(res);
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      4: return {{23{r[8]}}, r[8:0]};
      5: begin
        case (r[2:0])
          3'd0: return 32'h2000_0000;
          3'd1: return 32'hE000_0000;
          3'd2: return 32'h1FFF_FFFF;
          3'd3: return 32'hDFFF_FFFF;
          3'd4: return 32'h7FFF_FFFF;
          3'd5: return 32'h8000_0000;
          3'd6: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      6: return r[31] ? -(r >> r[4:0]) : (r >> r[4:0]);
      default: return r;
    endcase
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%s", msg);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    weighted_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    integrate_sample(s);
    @(negedge clk);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    @(negedge clk);
    while (level_queue.size() != 0) @(negedge clk);
    // non-snapshot items may still be in the pipe
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_coefficient(input logic [COEF_W-1:0] k);
    cfg_valid <= 1'b1;
    fast_coefficient <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    coef_shadow = k;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_random(input int n, input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_sample(random_sample());
  endtask

  task automatic test_edge_samples();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (EDGE_SAMPLES[i]) send_sample(EDGE_SAMPLES[i]);
    settle_block();
  endtask

  task automatic test_idle_phases();
    run_random(80, 0, 0);
    run_random(80, 76, 0);
    run_random(80, 0, 76);
    run_random(80, 13, 13);
    settle_block();
  endtask

  task automatic test_sender_pause();
    run_random(40, 0, 76);
    settle_block();
    run_random(40, 13, 13);
    settle_block();
  endtask

  task automatic test_coefficient_sweep();
    logic [COEF_W-1:0] coefs [6];
    coefs = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h0000, COEF_RESET};
    coefs[4] = COEF_W'($urandom);
    foreach (coefs[i]) begin
      write_coefficient(coefs[i]);
      case (i % 4)
        0: run_random(45, 0, 0);
        1: run_random(45, 76, 0);
        2: run_random(45, 0, 76);
        default: run_random(45, 13, 13);
      endcase
      settle_block();
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    out_fire <= out_valid && out_ready && !rst;
    out_level_q <= fast_level;
    out_wraps_q <= wrap_count;
  end

  always @(negedge clk) begin
    level_result_t exp_res;
    if (out_fire) begin
      if (level_queue.size() == 0) begin
        report_failure($sformatf("unexpected result: level %h wraps %h",
                                 out_level_q, out_wraps_q));
      end else begin
        exp_res = level_queue.pop_front();
        if (out_level_q !== exp_res.level || out_wraps_q !== exp_res.wraps)
          report_failure($sformatf(
            "result mismatch: fast_level exp %h got %h, wrap_count exp %h got %h",
            exp_res.level, out_level_q, exp_res.wraps, out_wraps_q));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    coef_shadow = COEF_RESET;
    energy_acc = '0;
    sample_index = '0;
    last_snapshot = '0;
    weight_delay = '0;
    weight_out = '0;
    wrap_total = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_edge_samples();
    test_idle_phases();
    test_sender_pause();
    test_coefficient_sweep();

    settle_block();
    if (level_queue.size() != 0)
      report_failure($sformatf("%0d results never arrived", level_queue.size()));
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> energy_integrator_fast_weighting.f
hdl/eifw_pkg.sv
hdl/eifw_square.sv
hdl/eifw_integrate.sv
hdl/eifw_filter.sv
hdl/energy_integrator_fast_weighting.sv
bench/tb_top.sv
